// ===== src/i2cs_pkg.sv =====
// Shared types and constants for the I2C slave response and receive ring block.
package i2cs_pkg;

	localparam logic [7:0] PENDING_RESET = 8'h55;
	localparam logic [7:0] RESP_BASE     = 8'h56;

	typedef enum logic [2:0] {
		MODE_START = 3'd0,
		MODE_STOP  = 3'd1,
		MODE_READ  = 3'd2,
		MODE_WRITE = 3'd3,
		MODE_POLL  = 3'd4,
		MODE_LOAD  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		ST_NONE   = 3'd0,
		ST_NEW    = 3'd1,
		ST_REQ    = 3'd2,
		ST_TX     = 3'd3,
		ST_ACCEPT = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data;
		logic [6:0] address;
		logic [2:0] slot;
		logic       final_req;
	} evt_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] byte_out;
		logic       is_stop;
		logic [6:0] matched_addr;
		logic       overflow;
	} res_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic mark;
	} ring_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} ring_sts_t;

endpackage

// ===== src/i2cs_rx_ring.sv =====
// Receive ring: byte memory with per-entry stop flags and registered pop data.
module i2cs_rx_ring
	import i2cs_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_ctl_t ctl,
	input  logic [7:0] wr_data,
	output ring_sts_t sts,
	output logic [7:0] rd_data,
	output logic      rd_stop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [FW-1:0] FULL = FW'(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] stop_q;
	logic [AW-1:0]    head_q, tail_q, newest;
	logic [FW-1:0]    fill_q;
	logic [7:0]       rd_data_q;
	logic             rd_stop_q;

	assign newest    = (head_q == '0) ? LAST : head_q - AW'(1);
	assign sts.empty = (fill_q == '0);
	assign sts.full  = (fill_q == FULL);
	assign rd_data   = rd_data_q;
	assign rd_stop   = rd_stop_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[head_q] <= wr_data;
		end
		if (ctl.pop) begin
			rd_data_q <= mem[tail_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			stop_q    <= '0;
			rd_stop_q <= 1'b0;
		end else begin
			if (ctl.push) begin
				stop_q[head_q] <= 1'b0;
				head_q         <= (head_q == LAST) ? '0 : head_q + AW'(1);
				fill_q         <= fill_q + FW'(1);
			end
			if (ctl.pop) begin
				rd_stop_q      <= stop_q[tail_q];
				stop_q[tail_q] <= 1'b0;
				tail_q         <= (tail_q == LAST) ? '0 : tail_q + AW'(1);
				fill_q         <= fill_q - FW'(1);
			end
			if (ctl.mark && !sts.empty) begin
				stop_q[newest] <= 1'b1;
			end
		end
	end

endmodule

// ===== src/i2c_slave_response_and_rx_fifo.sv =====
// I2C slave transaction logic: start/stop tracking, read responses and receive ring.
// Each bus or software event word yields exactly one result word. All state
// updates and the result are settled at the accepting edge, and the result is
// presented from an output register in the following cycle, so a new event can
// be taken in every cycle (one event per cycle) as long as results are taken.
// The ring pop data comes from the registered read port of the receive memory,
// read at that same edge. The result register frees itself when its word is
// taken, so the input stays ready while a finished result is being consumed.
module i2c_slave_response_and_rx_fifo
	import i2cs_pkg::*;
#(
	parameter int RING_DEPTH     = 32,
	parameter int RESPONSE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       evt_valid,
	output logic       evt_ready,
	input  evt_t       evt,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int IW = (RESPONSE_DEPTH > 1) ? $clog2(RESPONSE_DEPTH) : 1;
	localparam int CW = $clog2(RESPONSE_DEPTH + 1);
	localparam logic [CW-1:0] RESP_WRAP = CW'(RESPONSE_DEPTH);

	logic [7:0]    pending_q;
	logic [7:0]    store_q [RESPONSE_DEPTH];
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] send_q, send_d;
	logic          armed_q, armed_d;
	logic          req_q, req_d;
	logic [6:0]    addr_q, addr_d;

	logic          acc;
	logic          store_we;
	logic [CW-1:0] next_ext;
	ring_ctl_t     ring_ctl;
	ring_sts_t     ring_sts;
	logic [7:0]    ring_rd;
	logic          ring_stop;
	res_t          res_d, res_q;
	logic          pop_d, pop_q;
	logic          res_valid_q;

	assign evt_ready = !res_valid_q || res_ready;
	assign acc       = evt_valid && evt_ready;
	assign next_ext  = CW'(send_q) + CW'(1);

	always_comb begin
		count_d  = count_q;
		send_d   = send_q;
		armed_d  = armed_q;
		req_d    = req_q;
		addr_d   = addr_q;
		store_we = 1'b0;
		ring_ctl = '0;
		pop_d    = 1'b0;
		res_d    = '0;
		case (evt.mode)
			MODE_START: begin
				addr_d = evt.address;
				send_d = '0;
				if (count_q != '0) begin
					armed_d = 1'b1;
				end
			end
			MODE_STOP: begin
				send_d        = '0;
				count_d       = '0;
				armed_d       = 1'b0;
				req_d         = 1'b0;
				ring_ctl.mark = acc;
			end
			MODE_READ: begin
				addr_d       = evt.address;
				res_d.status = ST_TX;
				if (armed_q) begin
					res_d.byte_out = store_q[send_q];
					if (next_ext >= count_q) begin
						count_d = '0;
					end
					send_d = (next_ext == RESP_WRAP) ? '0 : IW'(next_ext);
				end else begin
					res_d.byte_out = pending_q;
					req_d          = 1'b1;
				end
			end
			MODE_WRITE: begin
				addr_d = evt.address;
				if (!ring_sts.full) begin
					ring_ctl.push = acc;
					res_d.status  = ST_ACCEPT;
				end else begin
					res_d.overflow = 1'b1;
				end
				if (CW'(send_q) >= count_q) begin
					count_d = '0;
				end
			end
			MODE_POLL: begin
				if (!ring_sts.empty) begin
					ring_ctl.pop = acc;
					pop_d        = 1'b1;
					res_d.status = ST_NEW;
				end else if (req_q) begin
					res_d.status = ST_REQ;
				end
			end
			MODE_LOAD: begin
				if (count_q == '0 && 32'(evt.slot) < RESPONSE_DEPTH) begin
					store_we = acc;
					if (evt.final_req) begin
						count_d = CW'(32'(evt.slot) + 32'd1);
						send_d  = '0;
					end
					res_d.status = ST_ACCEPT;
				end
			end
			default: begin
			end
		endcase
		res_d.matched_addr = addr_d;
	end

	i2cs_rx_ring #(
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.wr_data (evt.data),
		.sts     (ring_sts),
		.rd_data (ring_rd),
		.rd_stop (ring_stop)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= PENDING_RESET;
			for (int i = 0; i < RESPONSE_DEPTH; i++) begin
				store_q[i] <= RESP_BASE + 8'(i);
			end
			count_q     <= '0;
			send_q      <= '0;
			armed_q     <= 1'b0;
			req_q       <= 1'b0;
			addr_q      <= '0;
			res_valid_q <= 1'b0;
			pop_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				pending_q <= cfg_wdata;
			end
			if (store_we) begin
				store_q[IW'(evt.slot)] <= evt.data;
			end
			if (acc) begin
				count_q <= count_d;
				send_q  <= send_d;
				armed_q <= armed_d;
				req_q   <= req_d;
				addr_q  <= addr_d;
				pop_q   <= pop_d;
			end
			if (evt_ready) begin
				res_valid_q <= evt_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		res = res_q;
		if (pop_q) begin
			res.byte_out = ring_rd;
			res.is_stop  = ring_stop;
		end
	end

	assign res_valid = res_valid_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the I2C slave response and receive ring block, with a result scoreboard.
module testbench
	import i2cs_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_DEPTH     = 32;
	localparam int RESP_DEPTH   = 8;
	localparam int PHASE_WORDS  = 280;
	localparam int HOLD_CYCLES  = 120;
	localparam int STALL_LIMIT  = 4000;
	localparam int SHOW_ERRORS  = 10;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	class i2cs_scoreboard;
		logic [7:0] pending_byte;
		logic [7:0] resp_mem [RESP_DEPTH];
		logic [3:0] resp_count;
		logic [2:0] send_idx;
		bit         armed;
		bit         requested;
		logic [8:0] rx_mem [RX_DEPTH];
		logic [4:0] head;
		logic [4:0] tail;
		logic [5:0] fill;
		logic [6:0] last_addr;
		res_t       expected_q[$];
		int         errors;

		function new();
			pending_byte = PENDING_RESET;
			for (int i = 0; i < RESP_DEPTH; i++) begin
				resp_mem[i] = RESP_BASE + 8'(i);
			end
			resp_count = '0;
			send_idx = '0;
			armed = 0;
			requested = 0;
			head = '0;
			tail = '0;
			fill = '0;
			last_addr = '0;
			errors = 0;
		endfunction

		function void note_event(evt_t e);
			res_t r;
			int   nxt;
			r = '0;
			case (e.mode)
				MODE_START: begin
					last_addr = e.address;
					send_idx = '0;
					if (resp_count != 0) begin
						armed = 1;
					end
				end
				MODE_STOP: begin
					send_idx = '0;
					resp_count = '0;
					armed = 0;
					requested = 0;
					if (fill != 0) begin
						rx_mem[head - 5'd1][8] = 1'b1;
					end
				end
				MODE_READ: begin
					last_addr = e.address;
					r.status = ST_TX;
					if (armed) begin
						r.byte_out = resp_mem[send_idx];
						nxt = send_idx + 1;
						if (nxt >= resp_count) begin
							resp_count = '0;
						end
						send_idx = send_idx + 3'd1;
					end else begin
						r.byte_out = pending_byte;
						requested = 1;
					end
				end
				MODE_WRITE: begin
					last_addr = e.address;
					if (fill < RX_DEPTH) begin
						rx_mem[head] = {1'b0, e.data};
						head = head + 5'd1;
						fill = fill + 6'd1;
						r.status = ST_ACCEPT;
					end else begin
						r.overflow = 1'b1;
					end
					if (send_idx >= resp_count) begin
						resp_count = '0;
					end
				end
				MODE_POLL: begin
					if (fill != 0) begin
						r.is_stop = rx_mem[tail][8];
						r.byte_out = rx_mem[tail][7:0];
						rx_mem[tail][8] = 1'b0;
						tail = tail + 5'd1;
						fill = fill - 6'd1;
						r.status = ST_NEW;
					end else if (requested) begin
						r.status = ST_REQ;
					end
				end
				MODE_LOAD: begin
					if (resp_count == 0) begin
						resp_mem[e.slot] = e.data;
						if (e.final_req) begin
							resp_count = e.slot + 4'd1;
							send_idx = '0;
						end
						r.status = ST_ACCEPT;
					end
				end
				default: begin
				end
			endcase
			r.matched_addr = last_addr;
			expected_q.push_back(r);
		endfunction

		function void flag(string what, res_t got, res_t want);
			string want_s;
			string got_s;
			errors++;
			if (errors <= SHOW_ERRORS) begin
				want_s = $sformatf("st=%0d byte=%02h stop=%0b addr=%02h ovf=%0b",
					want.status, want.byte_out, want.is_stop,
					want.matched_addr, want.overflow);
				got_s = $sformatf("st=%0d byte=%02h stop=%0b addr=%02h ovf=%0b",
					got.status, got.byte_out, got.is_stop,
					got.matched_addr, got.overflow);
				$display("%0t %s: exp %s, got %s", $realtime, what, want_s, got_s);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				flag("result with nothing outstanding", got, '0);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.byte_out !== want.byte_out ||
					got.is_stop !== want.is_stop || got.matched_addr !== want.matched_addr ||
					got.overflow !== want.overflow) begin
				flag("wrong field", got, want);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       evt_valid = 1'b0;
	logic       evt_ready;
	evt_t       evt = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_t       res;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	i2cs_scoreboard sb = new();
	int src_idle = 0;
	int sink_stall = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int issued = 0;
	int quiet_cycles = 0;

	i2c_slave_response_and_rx_fifo uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			sb.check_result(res);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_valid && evt_ready) || (res_valid && res_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("i2c_slave_response_and_rx_fifo: mismatch");
				$finish;
			end
		end
	end

	function automatic evt_t mk(mode_t m, logic [7:0] d, logic [6:0] a, logic [2:0] s, logic f);
		evt_t e;
		e.mode = m;
		e.data = d;
		e.address = a;
		e.slot = s;
		e.final_req = f;
		return e;
	endfunction

	function automatic evt_t rnd(mode_t m);
		evt_t e;
		e = evt_t'($urandom);
		e.mode = m;
		return e;
	endfunction

	task automatic send(evt_t e);
		while ($urandom_range(99) < src_idle) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid <= 1'b1;
		evt <= e;
		do begin
			@(posedge clk);
		end while (!evt_ready);
		sb.note_event(e);
		issued++;
	endtask

	task automatic drain();
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_pending(logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.pending_byte = v;
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(int quota);
		int   first;
		int   pick;
		int   k;
		evt_t e;
		first = issued;
		while (issued - first < quota) begin
			pick = $urandom_range(99);
			if (pick < 18) begin
				k = $urandom_range(RESP_DEPTH, 1);
				for (int i = 0; i < k; i++) begin
					e = rnd(MODE_LOAD);
					e.slot = 3'(i);
					e.final_req = (i == k - 1);
					send(e);
				end
			end else if (pick < 40) begin
				send(rnd(MODE_START));
				k = $urandom_range(12, 1);
				for (int i = 0; i < k; i++) begin
					send(rnd(MODE_READ));
				end
				if ($urandom_range(9) != 0) begin
					send(rnd(MODE_STOP));
				end
			end else if (pick < 62) begin
				send(rnd(MODE_START));
				k = ($urandom_range(14) == 0) ? $urandom_range(40, 33) : $urandom_range(8, 1);
				for (int i = 0; i < k; i++) begin
					send(rnd(MODE_WRITE));
				end
				if ($urandom_range(6) != 0) begin
					send(rnd(MODE_STOP));
				end
			end else if (pick < 85) begin
				k = $urandom_range(10, 1);
				for (int i = 0; i < k; i++) begin
					send(rnd(MODE_POLL));
				end
			end else begin
				k = $urandom_range(3, 1);
				for (int i = 0; i < k; i++) begin
					send(evt_t'($urandom));
				end
			end
		end
		evt_valid <= 1'b0;
	endtask

	initial begin
		int         idle_src [4] = '{0, 80, 0, 14};
		int         idle_sink [4] = '{0, 0, 80, 14};
		logic [7:0] pend [4];
		pend = '{8'h00, 8'hFF, 8'($urandom), 8'hA5};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(MODE_POLL, 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_READ, 8'hFF, 7'h00, 3'd7, 1'b1));
		send(mk(MODE_POLL, 8'h00, 7'h7F, 3'd0, 1'b0));
		send(mk(MODE_POLL, 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_START, 8'h00, 7'h7F, 3'd0, 1'b0));
		send(mk(MODE_WRITE, 8'hFF, 7'h7F, 3'd0, 1'b0));
		send(mk(MODE_WRITE, 8'h00, 7'h2A, 3'd0, 1'b0));
		send(mk(MODE_STOP, 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_POLL, 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_POLL, 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_STOP, 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_POLL, 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_LOAD, 8'hAA, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_LOAD, 8'h55, 7'h00, 3'd1, 1'b1));
		send(mk(MODE_LOAD, 8'h99, 7'h00, 3'd2, 1'b1));
		send(mk(MODE_START, 8'h00, 7'h55, 3'd0, 1'b0));
		send(mk(MODE_READ, 8'h00, 7'h55, 3'd0, 1'b0));
		send(mk(MODE_READ, 8'h00, 7'h55, 3'd0, 1'b0));
		send(mk(MODE_READ, 8'h00, 7'h55, 3'd0, 1'b0));
		send(mk(MODE_WRITE, 8'h5A, 7'h55, 3'd0, 1'b0));
		send(mk(mode_t'(MODE_SPARE_LO), 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(mode_t'(MODE_SPARE_HI), 8'hFF, 7'h7F, 3'd7, 1'b1));
		send(mk(MODE_STOP, 8'h00, 7'h00, 3'd0, 1'b0));
		send(mk(MODE_LOAD, 8'h3C, 7'h00, 3'd7, 1'b0));
		evt_valid <= 1'b0;

		for (int p = 0; p < 4; p++) begin
			write_pending(pend[p]);
			src_idle = idle_src[p];
			sink_stall = idle_sink[p];
			if (p == 0) begin
				hold_req = 1;
			end
			run_random(PHASE_WORDS);
		end

		drain();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("i2c_slave_response_and_rx_fifo: match");
		end else begin
			$display("i2c_slave_response_and_rx_fifo: mismatch");
		end
		$finish;
	end

endmodule
